// ----- rtl/core/fqs_pkg.sv -----
// Package for the FIFO queue with search: depth, widths, command and status codes
// and the control struct handed to each storage cell. No dependencies.
`default_nettype none
package fqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic load;
    logic rotate;
    logic wrap;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/fqs_cell.sv -----
// One storage cell of the queue chain: holds one entry, loads a new value,
// or takes its neighbor's entry (or the head entry at the wrap point). Uses fqs_pkg.
`default_nettype none
module fqs_cell
  import fqs_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic signed [DATA_W-1:0] load_data,
  input  wire logic signed [DATA_W-1:0] next_data,
  input  wire logic signed [DATA_W-1:0] head_data,
  output logic signed [DATA_W-1:0]      data
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.rotate) begin
      data <= ctrl.wrap ? head_data : next_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/fifo_queue_with_search.sv -----
// Top level of the FIFO queue with search: command sequencer, output register
// and the chain of fqs_cell storage cells. Uses fqs_pkg and fqs_cell.
//
// Entries sit in a chain of QUEUE_DEPTH cells with the oldest in cell 0.
// Enqueue, dequeue and clear each give one result. Search and dump rotate
// the occupied part of the chain one cell per cycle when not held, reading
// cell 0, and the chain is back in order when they finish; a new command is
// accepted only after that. A result waits in the output register until taken;
// while it waits, a walk step that has a result to give holds, and a search
// past its match keeps rotating.
`default_nettype none
module fifo_queue_with_search
  import fqs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  wire logic [CMD_W-1:0]  s_axis_tuser,   // [2:0] cmd
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,   // [31:0] item
  output logic [STATUS_W-1:0]    m_axis_tuser,   // [2:0] status
  output logic                   m_axis_tlast
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t                     state, state_next;
  logic [CNT_W-1:0]           occupancy, occupancy_next;
  logic [CNT_W-1:0]           step, step_next;
  logic                       found, found_next;
  logic                       dump_mode, dump_mode_next;
  logic signed [DATA_W-1:0]   key, key_next;

  logic                       out_valid, out_valid_next;
  logic [STATUS_W-1:0]        out_status, out_status_next;
  logic signed [DATA_W-1:0]   out_item, out_item_next;
  logic                       out_last, out_last_next;

  logic signed [DATA_W-1:0]   cell_data [QUEUE_DEPTH];
  cell_ctrl_t                 cell_ctrl [QUEUE_DEPTH];

  logic                       can_emit;
  logic                       accept;
  logic                       do_load;
  logic                       do_rotate;
  logic [CNT_W-1:0]           occ_m1;
  logic                       last_step;
  logic                       match;
  logic                       empty;

  assign can_emit      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && can_emit;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign occ_m1        = occupancy - 1'b1;
  assign last_step     = (step == occ_m1);
  assign match         = (cell_data[0] == key);
  assign empty         = (occupancy == '0);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_item;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  always_comb begin
    state_next      = state;
    occupancy_next  = occupancy;
    step_next       = step;
    found_next      = found;
    dump_mode_next  = dump_mode;
    key_next        = key;
    out_valid_next  = out_valid && !m_axis_tready;
    out_status_next = out_status;
    out_item_next   = out_item;
    out_last_next   = out_last;
    do_load         = 1'b0;
    do_rotate       = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          out_item_next = '0;
          out_last_next = 1'b1;
          case (s_axis_tuser)
            CMD_ENQUEUE: begin
              out_valid_next = 1'b1;
              if (occupancy == CNT_W'(QUEUE_DEPTH)) begin
                out_status_next = ST_FULL;
              end else begin
                do_load         = 1'b1;
                occupancy_next  = occupancy + 1'b1;
                out_status_next = ST_DONE;
              end
            end
            CMD_SEARCH, CMD_DUMP: begin
              if (empty) begin
                out_valid_next  = 1'b1;
                out_status_next = ST_EMPTY;
              end else begin
                state_next     = S_WALK;
                step_next      = '0;
                found_next     = 1'b0;
                dump_mode_next = (s_axis_tuser == CMD_DUMP);
                key_next       = s_axis_tdata;
              end
            end
            CMD_DEQUEUE: begin
              out_valid_next = 1'b1;
              if (empty) begin
                out_status_next = ST_EMPTY;
              end else begin
                do_rotate       = 1'b1;
                occupancy_next  = occ_m1;
                out_status_next = ST_DONE;
                out_item_next   = cell_data[0];
              end
            end
            CMD_CLEAR: begin
              out_valid_next = 1'b1;
              if (empty) begin
                out_status_next = ST_EMPTY;
              end else begin
                occupancy_next  = '0;
                out_status_next = ST_DONE;
              end
            end
            default: begin
              out_valid_next = out_valid && !m_axis_tready;
            end
          endcase
        end
      end
      S_WALK: begin
        if (dump_mode) begin
          if (can_emit) begin
            do_rotate       = 1'b1;
            step_next       = step + 1'b1;
            out_valid_next  = 1'b1;
            out_status_next = ST_DONE;
            out_item_next   = cell_data[0];
            out_last_next   = last_step;
            if (last_step) begin
              state_next = S_IDLE;
            end
          end
        end else if (!(!found && (match || last_step)) || can_emit) begin
          do_rotate  = 1'b1;
          step_next  = step + 1'b1;
          found_next = found || match;
          if (!found && (match || last_step)) begin
            out_valid_next  = 1'b1;
            out_status_next = match ? ST_FOUND : ST_NOT_FOUND;
            out_item_next   = match ? cell_data[0] : '0;
            out_last_next   = 1'b1;
          end
          if (last_step) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      step      <= '0;
      found     <= 1'b0;
      dump_mode <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occupancy <= occupancy_next;
      step      <= step_next;
      found     <= found_next;
      dump_mode <= dump_mode_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key        <= key_next;
    out_status <= out_status_next;
    out_item   <= out_item_next;
    out_last   <= out_last_next;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] next_data;

    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign next_data = cell_data[0];
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    assign cell_ctrl[i].load   = do_load && (occupancy == CNT_W'(i));
    assign cell_ctrl[i].rotate = do_rotate;
    assign cell_ctrl[i].wrap   = (occ_m1 == CNT_W'(i));

    fqs_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .load_data (s_axis_tdata),
      .next_data (next_data),
      .head_data (cell_data[0]),
      .data      (cell_data[i])
    );
  end

endmodule
`default_nettype wire

// ----- sim/fifo_queue_with_search_check.sv -----
`timescale 1ns / 1ps
// Checker for the FIFO queue with search: watches both stream channels, predicts
// each command's results from its own copy of the queue and compares them in order.
// Depends on fqs_pkg for widths and command and status codes.
module fifo_queue_with_search_check
  import fqs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_valid,
  input  wire logic                s_ready,
  input  wire logic [DATA_W-1:0]   s_data,
  input  wire logic [CMD_W-1:0]    s_user,
  input  wire logic                m_valid,
  input  wire logic                m_ready,
  input  wire logic [DATA_W-1:0]   m_data,
  input  wire logic [STATUS_W-1:0] m_user,
  input  wire logic                m_last,
  output int unsigned              fail_count,
  output int unsigned              pending
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   item;
    logic                last;
  } queue_result_t;

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [IDX_W-1:0]  head_idx;
  logic [IDX_W-1:0]  tail_idx;
  logic [CNT_W-1:0]  fill;
  queue_result_t     expected_results [$];

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic void expect_result(input logic [STATUS_W-1:0] status,
                                        input logic [DATA_W-1:0] item, input logic last);
    queue_result_t r;
    r.status = status;
    r.item   = item;
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  task automatic predict_queue_results(input logic [CMD_W-1:0] cmd,
                                       input logic [DATA_W-1:0] key);
    logic [IDX_W-1:0] pos;
    logic             hit;
    int               i;
    pos = head_idx;
    hit = 1'b0;
    case (cmd)
      CMD_ENQUEUE: begin
        if (int'(fill) >= QUEUE_DEPTH) begin
          expect_result(ST_FULL, '0, 1'b1);
        end else begin
          slots[tail_idx] = key;
          tail_idx = ring_next(tail_idx);
          fill = fill + 1'b1;
          expect_result(ST_DONE, '0, 1'b1);
        end
      end
      CMD_SEARCH: begin
        if (fill == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < int'(fill); i++) begin
            if (slots[pos] == key) hit = 1'b1;
            pos = ring_next(pos);
          end
          if (hit) expect_result(ST_FOUND, key, 1'b1);
          else expect_result(ST_NOT_FOUND, '0, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (fill == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < int'(fill); i++) begin
            expect_result(ST_DONE, slots[pos], i == int'(fill) - 1);
            pos = ring_next(pos);
          end
        end
      end
      CMD_DEQUEUE: begin
        if (fill == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          expect_result(ST_DONE, slots[head_idx], 1'b1);
          head_idx = ring_next(head_idx);
          fill = fill - 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (fill == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          head_idx = '0;
          tail_idx = '0;
          fill = '0;
          expect_result(ST_DONE, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      head_idx = '0;
      tail_idx = '0;
      fill = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (s_valid && s_ready) predict_queue_results(s_user, s_data);
      if (m_valid && m_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status=%0d item=%h last=%b",
                   $time, m_user, m_data, m_last);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_user !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, m_user);
            fail_count++;
          end
          if (m_data !== want.item) begin
            $display("%0t: item mismatch, expected %h, actual %h", $time, want.item, m_data);
            fail_count++;
          end
          if (m_last !== want.last) begin
            $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, m_last);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- sim/fifo_queue_with_search_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the FIFO queue with search: clock, reset, command stimulus and
// random handshake gaps; the checker module judges results. Uses fqs_pkg.
module fifo_queue_with_search_test;
  import fqs_pkg::*;

  localparam int RANDOM_CMDS = 75;
  localparam int HOLD_AT     = 35;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 100000;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata = '0;
  logic [CMD_W-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic                m_axis_tlast;

  int unsigned         fail_count;
  int unsigned         pending;
  int                  accepted_cmds = 0;
  int                  real_cmds = 0;
  bit                  eager = 1'b0;
  logic [DATA_W-1:0]   recent_keys [8] = '{default: '0};
  int                  recent_wr = 0;

  fifo_queue_with_search uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  fifo_queue_with_search_check checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_data     (s_axis_tdata),
    .s_user     (s_axis_tuser),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_data     (m_axis_tdata),
    .m_user     (m_axis_tuser),
    .m_last     (m_axis_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("fifo_queue_with_search verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    if (r < 70) return DATA_W'(int'($urandom_range(0, 8)) - 4);
    if (r < 85) return recent_keys[$urandom_range(0, 7)];
    case ($urandom_range(0, 3))
      0: return {1'b1, {(DATA_W - 1){1'b0}}};
      1: return {1'b0, {(DATA_W - 1){1'b1}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 6) return recent_keys[$urandom_range(0, 7)];
    return pick_value();
  endfunction

  // leave tvalid high after the transfer; the caller drops it when done
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
    int gap;
    gap = eager ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    accepted_cmds++;
    if (cmd <= CMD_CLEAR) real_cmds++;
    if (cmd == CMD_ENQUEUE) begin
      recent_keys[recent_wr] = value;
      recent_wr = (recent_wr + 1) % 8;
    end
  endtask

  initial begin : sink
    int gap;
    int burst;
    bit held;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held && accepted_cmds >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 12);
      m_axis_tready <= 1'b1;
      repeat (burst) @(posedge clk);
    end
  end

  initial begin : stimulus
    int base;
    int kind;
    int n;
    int r;
    int c;
    int waited;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_cmd(CMD_SEARCH, 32'h0000_0001);
    send_cmd(CMD_DUMP, '0);
    send_cmd(CMD_DEQUEUE, '0);
    send_cmd(CMD_CLEAR, '0);
    for (c = int'(CMD_CLEAR) + 1; c < 2 ** CMD_W; c++) send_cmd(CMD_W'(c), '1);
    send_cmd(CMD_ENQUEUE, 32'h8000_0000);
    send_cmd(CMD_ENQUEUE, 32'h7FFF_FFFF);
    send_cmd(CMD_ENQUEUE, 32'h0000_0000);
    send_cmd(CMD_ENQUEUE, 32'hFFFF_FFFF);
    send_cmd(CMD_ENQUEUE, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 32'h8000_0000);
    send_cmd(CMD_SEARCH, 32'h0000_0000);
    send_cmd(CMD_SEARCH, 32'h1234_5678);
    send_cmd(CMD_DUMP, '0);
    send_cmd(CMD_DEQUEUE, '0);
    send_cmd(CMD_CLEAR, '0);
    send_cmd(CMD_ENQUEUE, 32'h0000_0005);
    send_cmd(CMD_DEQUEUE, '0);
    send_cmd(CMD_DEQUEUE, '0);

    base = real_cmds;
    while (real_cmds - base < RANDOM_CMDS) begin
      eager = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        n = $urandom_range(8, 20);
        repeat (n) send_cmd(CMD_ENQUEUE, pick_value());
        send_cmd(CMD_SEARCH, pick_key());
        send_cmd(CMD_DUMP, $urandom());
      end else if (kind < 5) begin
        n = $urandom_range(4, 18);
        repeat (n) send_cmd(CMD_DEQUEUE, $urandom());
      end else begin
        n = $urandom_range(4, 12);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 35) send_cmd(CMD_ENQUEUE, pick_value());
          else if (r < 57) send_cmd(CMD_SEARCH, pick_key());
          else if (r < 77) send_cmd(CMD_DEQUEUE, $urandom());
          else if (r < 89) send_cmd(CMD_DUMP, $urandom());
          else if (r < 95) send_cmd(CMD_CLEAR, $urandom());
          else send_cmd(CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, 2 ** CMD_W - 1)),
                        $urandom());
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("fifo_queue_with_search verification clean");
    end else begin
      $display("fifo_queue_with_search verification failed");
    end
    $finish;
  end

endmodule
